FILE: rtl/dogx_pkg.sv
// Shared types and constants for the DoG scale-space extremum detector.
// No dependencies; the lane, merge, top-level and checker files import it.
`timescale 1ns / 1ps

package dogx_pkg;

  // Configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 12'd1024;

  // Result word layout
  localparam int ROW_BITS      = 12;
  localparam int OUT_COL_BITS  = 10;
  localparam int OUT_VAL_BITS  = 16;
  localparam int OUT_DATA_BITS = 40;

  // What one layer lane reports about its nine (or eight) neighbors
  typedef struct packed {
    logic above_all;  // every neighbor strictly below the centre
    logic below_all;  // every neighbor strictly above the centre
  } lane_flags_t;

endpackage

FILE: rtl/dogx_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dogx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/dogx_lane.sv
// One scale-layer lane: two-row line store, 3x2 window registers and the
// nine neighbor compares against the centre. Depends on dogx_pkg, dogx_ram.
`timescale 1ns / 1ps

module dogx_lane import dogx_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter bit IS_CENTRE   = 1'b0,
  localparam int COL_BITS   = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [COL_BITS-1:0]           load_addr,
  input  logic signed [SAMPLE_BITS-1:0] load_sample,
  input  logic                          odd_row,
  input  logic                          advance,
  input  logic                          clear,
  input  logic [COL_BITS-1:0]           store_addr,
  input  logic signed [SAMPLE_BITS-1:0] centre,
  output logic signed [SAMPLE_BITS-1:0] centre_here,
  output lane_flags_t                   flags
);

  logic [2*SAMPLE_BITS-1:0]      rd_word;
  logic [2*SAMPLE_BITS-1:0]      wr_word;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] win [3][2];
  logic signed [SAMPLE_BITS-1:0] cur [3];

  // Each word keeps both row banks of one column: even rows low, odd rows high.
  dogx_ram #(
    .WIDTH (2*SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (advance || clear),
    .wr_addr (store_addr),
    .wr_data (wr_word),
    .rd_en   (load),
    .rd_addr (load_addr),
    .rd_data (rd_word)
  );

  // Newest column of the window: row-2, row-1, arriving row
  always_comb begin
    if (odd_row) begin
      cur[0] = rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
      cur[1] = rd_word[SAMPLE_BITS-1:0];
    end else begin
      cur[0] = rd_word[SAMPLE_BITS-1:0];
      cur[1] = rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
    cur[2] = sample_q;
  end

  // Overwrite this row's bank, keep the other; zero both while clearing
  always_comb begin
    if (clear) begin
      wr_word = '0;
    end else if (odd_row) begin
      wr_word = {sample_q, rd_word[SAMPLE_BITS-1:0]};
    end else begin
      wr_word = {rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS], sample_q};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_q <= load_sample;
    end
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= cur[k];
      end
    end
  end

  assign centre_here = win[1][1];

  always_comb begin
    flags.above_all = 1'b1;
    flags.below_all = 1'b1;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 2; j++) begin
        if (!(IS_CENTRE && k == 1 && j == 1)) begin
          if (win[k][j] >= centre) flags.above_all = 1'b0;
          if (win[k][j] <= centre) flags.below_all = 1'b0;
        end
      end
      if (cur[k] >= centre) flags.above_all = 1'b0;
      if (cur[k] <= centre) flags.below_all = 1'b0;
    end
  end

endmodule

FILE: rtl/dogx_merge.sv
// Merge stage: combines the three lane verdicts with the border test and
// holds the result word until taken. Depends on dogx_pkg.
`timescale 1ns / 1ps

module dogx_merge import dogx_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int COL_BITS   = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic [ROW_BITS-1:0]           row,
  input  logic [COL_BITS-1:0]           col,
  input  logic signed [SAMPLE_BITS-1:0] centre,
  input  lane_flags_t [2:0]             flags,
  output logic                          out_valid,
  output logic [OUT_DATA_BITS-1:0]      out_data,
  output logic                          out_user
);

  localparam int CV_KEEP = (SAMPLE_BITS < OUT_VAL_BITS) ? SAMPLE_BITS : OUT_VAL_BITS;

  logic                    interior;
  logic                    is_max;
  logic                    is_min;
  logic [ROW_BITS-1:0]     centre_row;
  logic [OUT_COL_BITS-1:0] centre_col;
  logic [OUT_VAL_BITS-1:0] centre_value;

  assign interior = (row >= ROW_BITS'(2)) && (col >= COL_BITS'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // Border results carry zeros in every field
  always_ff @(posedge clk) begin
    if (advance) begin
      out_user <= interior;
      is_max   <= interior && (centre > 0) && flags[0].above_all
                  && flags[1].above_all && flags[2].above_all;
      is_min   <= interior && (centre < 0) && flags[0].below_all
                  && flags[1].below_all && flags[2].below_all;
      centre_row   <= interior ? ROW_BITS'(row - ROW_BITS'(1)) : '0;
      centre_col   <= interior ? OUT_COL_BITS'(col - COL_BITS'(1)) : '0;
      centre_value <= interior ? OUT_VAL_BITS'(centre[CV_KEEP-1:0]) : '0;
    end
  end

  assign out_data = {centre_value, centre_col, centre_row, is_min, is_max};

endmodule

FILE: rtl/dog_scale_space_extremum_detector.sv
// Top level of the DoG 3x3x3 extremum detector: position counters, three
// layer lanes and the merge stage. Depends on dogx_pkg, dogx_lane, dogx_merge.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake                Word
// s_axis    in   s_axis_tvalid/tready     tdata: lower, middle, upper sample
// m_axis    out  m_axis_tvalid/tready     tdata + tuser (centre_valid)
// cfg       in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One input word per clock unless clearing or stalled by m_axis; each word
// yields exactly one result word via the read stage (line store read, one
// registered RAM port per lane) and result register; compare stage sets clock.
// After reset a clearing pass writes zeros to every line store address;
// s_axis_tready stays low meanwhile, cfg writes are taken.
// When m_axis stalls, the result register holds and, if the read stage is
// empty, one more input word is taken into it; then the input side stalls too.
//
// Windows are centred one row above and one column left of the arriving
// pixel. Rows 0 and 1 and columns 0 and 1 give border results (all zero).

module dog_scale_space_extremum_detector import dogx_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_DATA_BITS = ((3*SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // slave stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // lower_sample, middle_sample,
                                                   // upper_sample, zero pad
  // master stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // is_maximum, is_minimum,
                                                   // centre_row, centre_col,
                                                   // centre_value
  output logic                     m_axis_tuser,   // centre_valid
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WB       = $clog2(MAX_WIDTH + 1);
  localparam int EXT_BITS = (WB > CFG_W_BITS) ? WB : CFG_W_BITS;

  // Configuration
  logic [CFG_W_BITS-1:0] image_width;
  logic [CFG_H_BITS-1:0] image_height;
  logic [EXT_BITS-1:0]   width_ext;
  logic [EXT_BITS-1:0]   eff_width;
  logic [CFG_H_BITS-1:0] eff_height;

  // Position of the next arriving pixel
  logic [ROW_BITS-1:0]   row_pos;
  logic [COL_BITS-1:0]   col_pos;
  logic                  col_last;
  logic                  row_last;

  // Read stage
  logic                  s1_valid;
  logic [ROW_BITS-1:0]   s1_row;
  logic [COL_BITS-1:0]   s1_col;

  // Clearing pass
  logic                  clearing;
  logic [COL_BITS-1:0]   clr_addr;

  logic                  advance;
  logic                  accept;
  logic                  fire;
  logic [COL_BITS-1:0]   store_addr;

  logic signed [SAMPLE_BITS-1:0] in_sample [3];
  logic signed [SAMPLE_BITS-1:0] lane_centre [3];
  lane_flags_t [2:0]             lane_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width to [3, MAX_WIDTH] and height to at least 3
  assign width_ext = EXT_BITS'(image_width);

  always_comb begin
    if (width_ext < EXT_BITS'(3)) begin
      eff_width = EXT_BITS'(3);
    end else if (width_ext > EXT_BITS'(MAX_WIDTH)) begin
      eff_width = EXT_BITS'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    eff_height = (image_height < CFG_H_BITS'(3)) ? CFG_H_BITS'(3) : image_height;
  end

  assign col_last = (EXT_BITS'(col_pos) + EXT_BITS'(1)) >= eff_width;
  assign row_last = ({1'b0, row_pos} + (ROW_BITS+1)'(1)) >= {1'b0, eff_height};

  // Whole pipe moves when the result register is free or being taken
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !clearing && (!s1_valid || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_BITS'(1);
      if (clr_addr == COL_BITS'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Advance raster position on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_pos <= '0;
        row_pos <= row_last ? '0 : row_pos + ROW_BITS'(1);
      end else begin
        col_pos <= col_pos + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= row_pos;
      s1_col <= col_pos;
    end
  end

  assign store_addr = clearing ? clr_addr : s1_col;

  assign in_sample[0] = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_sample[1] = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_sample[2] = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  // Lane 0: lower layer, lane 1: layer under test, lane 2: upper layer
  for (genvar l = 0; l < 3; l++) begin : g_lane
    dogx_lane #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IS_CENTRE   (l == 1)
    ) u_lane (
      .clk         (clk),
      .load        (accept),
      .load_addr   (col_pos),
      .load_sample (in_sample[l]),
      .odd_row     (s1_row[0]),
      .advance     (fire),
      .clear       (clearing),
      .store_addr  (store_addr),
      .centre      (lane_centre[1]),
      .centre_here (lane_centre[l]),
      .flags       (lane_flags[l])
    );
  end

  dogx_merge #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s1_valid),
    .row       (s1_row),
    .col       (s1_col),
    .centre    (lane_centre[1]),
    .flags     (lane_flags),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

FILE: rtl/dogx_checker.sv
// Port-level checks for the DoG extremum detector, bound to the top level.
// Depends on dogx_pkg and dog_scale_space_extremum_detector.
`timescale 1ns / 1ps

module dogx_checker import dogx_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                     m_axis_tuser
);

  // Reset empties the pipe and starts the clearing pass
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("output valid or input ready right after reset");

  // Stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Border results carry all-zero fields
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("border result with nonzero fields");

  // A centre cannot be both maximum and minimum
  a_max_min_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("maximum and minimum flagged together");

endmodule

bind dog_scale_space_extremum_detector dogx_checker u_checker (.*);
